FILE: design/jdf_pkg.sv
// Package for the joystick to drive frame block: payload, configuration and
// job types, register indexes, reset values and frame characters.
// No dependencies.
`default_nettype none

package jdf_pkg;

  // Input item: one sample pair and the mode switch
  typedef struct packed {
    logic [11:0] x_sample;
    logic [11:0] y_sample;
    logic        auto_mode;
  } jdf_in_t;

  // Result item: one frame character
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } jdf_out_t;

  // Configuration seen by the front end
  typedef struct packed {
    logic [11:0] centre_value;
    logic [10:0] dead_zone;
    logic [11:0] high_threshold;
    logic [11:0] low_threshold;
  } jdf_cfg_t;

  // Classified item passed from front to back: direction and clamped distance
  typedef struct packed {
    logic [7:0]  dir;
    logic [10:0] defl;
  } jdf_job_t;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_CENTRE = 2'd0;
  localparam logic [1:0] REG_DEAD   = 2'd1;
  localparam logic [1:0] REG_HIGH   = 2'd2;
  localparam logic [1:0] REG_LOW    = 2'd3;

  // Reset values
  localparam logic [11:0] CENTRE_RST = 12'd2048;
  localparam logic [10:0] DEAD_RST   = 11'd300;
  localparam logic [11:0] HIGH_RST   = 12'd2350;
  localparam logic [11:0] LOW_RST    = 12'd1750;

  // Distance saturation after the dead zone
  localparam logic [11:0] DIST_CLAMP = 12'd1300;

  // speed = floor(d*d/1690), done as (d*d*SPD_RECIP) >> 32, exact for d <= 1300
  localparam logic [21:0] SPD_RECIP = 22'd2541401;
  localparam logic [9:0]  SPD_MAX   = 10'd1000;

  // Frame characters
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_F      = 8'h46;
  localparam logic [7:0] CH_B      = 8'h42;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_L      = 8'h4C;

endpackage

`default_nettype wire

FILE: design/jdf_front.sv
// Front end: accepts sample items, picks the direction and deciding sample,
// and pushes the clamped distance into the job queue. Uses jdf_pkg.
`default_nettype none

module jdf_front #(
  parameter int SAMPLE_BITS = 12
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  jdf_pkg::jdf_in_t    in_data,
  input  jdf_pkg::jdf_cfg_t   cfg,
  input  wire                 q_full,
  output logic                q_push,
  output jdf_pkg::jdf_job_t   q_data
);
  import jdf_pkg::*;

  localparam int          MASK_BITS   = (SAMPLE_BITS > 12) ? 12 : SAMPLE_BITS;
  localparam logic [11:0] SAMPLE_MASK = 12'((32'd1 << MASK_BITS) - 32'd1);

  logic        front_v_r, front_v_nxt;
  logic [7:0]  front_dir_r, front_dir_nxt;
  logic [11:0] front_smp_r, front_smp_nxt;
  logic [11:0] x_m, y_m;
  logic        in_acc;
  logic [11:0] diff, over;
  logic [10:0] defl;

  // Classification of the incoming item
  always_comb begin
    x_m           = in_data.x_sample & SAMPLE_MASK;
    y_m           = in_data.y_sample & SAMPLE_MASK;
    front_dir_nxt = CH_S;
    front_smp_nxt = x_m;
    if (!in_data.auto_mode) begin
      if (y_m > cfg.high_threshold) begin
        front_dir_nxt = CH_F;
        front_smp_nxt = y_m;
      end else if (y_m < cfg.low_threshold) begin
        front_dir_nxt = CH_B;
        front_smp_nxt = y_m;
      end else if (x_m > cfg.high_threshold) begin
        front_dir_nxt = CH_R;
      end else if (x_m < cfg.low_threshold) begin
        front_dir_nxt = CH_L;
      end
    end
  end

  // Handshake: one holding register ahead of the queue
  assign q_push   = front_v_r && !q_full;
  assign in_ready = !front_v_r || q_push;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    front_v_nxt = front_v_r;
    if (in_acc) begin
      front_v_nxt = 1'b1;
    end else if (q_push) begin
      front_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_v_r <= 1'b0;
    end else begin
      front_v_r <= front_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      front_dir_r <= front_dir_nxt;
      front_smp_r <= front_smp_nxt;
    end
  end

  // Distance from centre, less dead zone, saturated
  always_comb begin
    diff = (front_smp_r > cfg.centre_value) ? (front_smp_r - cfg.centre_value)
                                            : (cfg.centre_value - front_smp_r);
    over = diff - {1'b0, cfg.dead_zone};
    if (front_dir_r == CH_S || diff < {1'b0, cfg.dead_zone}) begin
      defl = 11'd0;
    end else if (over > DIST_CLAMP) begin
      defl = DIST_CLAMP[10:0];
    end else begin
      defl = over[10:0];
    end
    q_data.dir  = front_dir_r;
    q_data.defl = defl;
  end

`ifndef NO_ASSERTIONS
  // Auto mode always yields the stop direction
  a_auto_stop: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.auto_mode |=> front_dir_r == CH_S)
    else $error("auto mode item not classified as stop");
`endif

endmodule

`default_nettype wire

FILE: design/jdf_queue.sv
// Two-entry job queue between the front end and the frame back end.
// Uses jdf_pkg for the job type.
`default_nettype none

module jdf_queue (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                push,
  input  jdf_pkg::jdf_job_t  push_data,
  output logic               full,
  input  wire                pop,
  output logic               head_valid,
  output jdf_pkg::jdf_job_t  head_data
);
  import jdf_pkg::*;

  jdf_job_t   slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head_data  = slot_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef NO_ASSERTIONS
  // Fill count stays within the two slots
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("queue fill count out of range");
  // Pointers differ exactly when the queue holds one item
  a_ptr_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r != rd_ptr_r) == (cnt_r == 2'd1))
    else $error("queue pointers disagree with fill count");
`endif

endmodule

`default_nettype wire

FILE: design/jdf_back.sv
// Back end, uses jdf_pkg: squares the distance, scales it to a speed, splits it
// into decimal digits, sends the frame one character per cycle while out_ready.
`default_nettype none

module jdf_back (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                q_valid,
  input  jdf_pkg::jdf_job_t  q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  wire                out_ready,
  output jdf_pkg::jdf_out_t  out_data
);
  import jdf_pkg::*;

  // Stage 1: square
  logic        s1_v_r, s1_v_nxt;
  logic [7:0]  s1_dir_r;
  logic [20:0] s1_sq_r;
  logic [21:0] sq_full;
  // Stage 2: speed
  logic        s2_v_r, s2_v_nxt;
  logic [7:0]  s2_dir_r;
  logic [9:0]  s2_spd_r;
  logic [42:0] spd_prod;
  // Stage 3: hundreds and remainder
  logic        s3_v_r, s3_v_nxt;
  logic [7:0]  s3_dir_r;
  logic        s3_thou_r;
  logic [3:0]  s3_hun_r;
  logic [6:0]  s3_rem_r;
  logic [15:0] hun_prod;
  logic [3:0]  hun;
  logic [9:0]  rem_full;
  // Frame being sent
  logic            fr_v_r, fr_v_nxt;
  logic [7:0]      fr_dir_r;
  logic [3:0][3:0] fr_dg_r, dg_nxt;
  logic [2:0]      fr_nd_r, nd_nxt;
  logic [3:0]      pos_r, pos_nxt;
  logic [14:0]     ten_prod;
  logic [3:0]      ten, one;
  logic [6:0]      one_full;
  // Output register
  logic     out_v_r, out_v_nxt;
  jdf_out_t out_data_r, byte_nxt;
  // Flow control
  logic       out_adv, fr_last, fr_free, fr_load, s3_load, s2_load, s1_load;
  logic [3:0] last_pos;
  logic [1:0] dg_idx;

  // Stall chain from the output back to the queue
  always_comb begin
    last_pos = 4'd5 + {1'b0, fr_nd_r};
    out_adv  = !out_v_r || out_ready;
    fr_last  = fr_v_r && (pos_r == last_pos);
    fr_free  = !fr_v_r || (out_adv && fr_last);
    fr_load  = s3_v_r && fr_free;
    s3_load  = s2_v_r && (!s3_v_r || fr_load);
    s2_load  = s1_v_r && (!s2_v_r || s3_load);
    s1_load  = q_valid && (!s1_v_r || s2_load);
    q_pop    = s1_load;
  end

  // Stage valids
  always_comb begin
    s1_v_nxt = s1_load ? 1'b1 : (s2_load ? 1'b0 : s1_v_r);
    s2_v_nxt = s2_load ? 1'b1 : (s3_load ? 1'b0 : s2_v_r);
    s3_v_nxt = s3_load ? 1'b1 : (fr_load ? 1'b0 : s3_v_r);
    fr_v_nxt = fr_load ? 1'b1 : (fr_last && out_adv ? 1'b0 : fr_v_r);
  end

  // Arithmetic per stage
  always_comb begin
    sq_full  = {11'd0, q_data.defl} * {11'd0, q_data.defl};
    spd_prod = {22'd0, s1_sq_r} * {21'd0, SPD_RECIP};
    hun_prod = {6'd0, s2_spd_r} * 16'd41;
    hun      = hun_prod[15:12];
    rem_full = s2_spd_r - ({6'd0, hun} * 10'd100);
    ten_prod = {8'd0, s3_rem_r} * 15'd205;
    ten      = ten_prod[14:11];
    one_full = s3_rem_r - ({3'd0, ten} * 7'd10);
    one      = one_full[3:0];
  end

  // Digits, most significant first, and their count
  always_comb begin
    dg_nxt = '0;
    if (s3_thou_r) begin
      dg_nxt[0] = 4'd1;
      nd_nxt    = 3'd4;
    end else if (s3_hun_r != 4'd0) begin
      dg_nxt[0] = s3_hun_r;
      dg_nxt[1] = ten;
      dg_nxt[2] = one;
      nd_nxt    = 3'd3;
    end else if (ten != 4'd0) begin
      dg_nxt[0] = ten;
      dg_nxt[1] = one;
      nd_nxt    = 3'd2;
    end else begin
      dg_nxt[0] = one;
      nd_nxt    = 3'd1;
    end
  end

  // Character at the current frame position
  always_comb begin
    dg_idx              = 2'(pos_r - 4'd5);
    byte_nxt.last_byte  = 1'b0;
    if (pos_r == 4'd0) begin
      byte_nxt.frame_byte = CH_DOLLAR;
    end else if (pos_r == 4'd1) begin
      byte_nxt.frame_byte = CH_M;
    end else if (pos_r == 4'd2 || pos_r == 4'd4) begin
      byte_nxt.frame_byte = CH_COMMA;
    end else if (pos_r == 4'd3) begin
      byte_nxt.frame_byte = fr_dir_r;
    end else if (pos_r == last_pos) begin
      byte_nxt.frame_byte = CH_HASH;
      byte_nxt.last_byte  = 1'b1;
    end else begin
      byte_nxt.frame_byte = CH_ZERO + {4'd0, fr_dg_r[dg_idx]};
    end
  end

  // Frame position and output register
  always_comb begin
    pos_nxt   = pos_r;
    out_v_nxt = out_v_r;
    if (fr_load) begin
      pos_nxt = 4'd0;
    end else if (fr_v_r && out_adv) begin
      pos_nxt = pos_r + 4'd1;
    end
    if (out_adv) begin
      out_v_nxt = fr_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      fr_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      pos_r   <= 4'd0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      s2_v_r  <= s2_v_nxt;
      s3_v_r  <= s3_v_nxt;
      fr_v_r  <= fr_v_nxt;
      out_v_r <= out_v_nxt;
      pos_r   <= pos_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_dir_r <= q_data.dir;
      s1_sq_r  <= sq_full[20:0];
    end
    if (s2_load) begin
      s2_dir_r <= s1_dir_r;
      s2_spd_r <= spd_prod[41:32];
    end
    if (s3_load) begin
      s3_dir_r  <= s2_dir_r;
      s3_thou_r <= (s2_spd_r == SPD_MAX);
      s3_hun_r  <= hun;
      s3_rem_r  <= rem_full[6:0];
    end
    if (fr_load) begin
      fr_dir_r <= s3_dir_r;
      fr_dg_r  <= dg_nxt;
      fr_nd_r  <= nd_nxt;
    end
    if (out_adv && fr_v_r) begin
      out_data_r <= byte_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  // Frame position never runs past the closing character
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    fr_v_r |-> pos_r <= last_pos)
    else $error("frame position beyond closing character");
  // Last flag only on the closing hash
  a_last_hash: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_data_r.last_byte |-> out_data_r.frame_byte == CH_HASH)
    else $error("last flag on a character other than hash");
  // Digit count of a loaded frame is between one and four
  a_nd_range: assert property (@(posedge clk) disable iff (!rst_n)
    fr_v_r |-> (fr_nd_r >= 3'd1 && fr_nd_r <= 3'd4))
    else $error("digit count out of range");
`endif

endmodule

`default_nettype wire

FILE: design/joystick_to_drive_frame.sv
// Joystick to drive frame, top level: APB register file, front end, job queue
// and frame back end. Depends on jdf_pkg, jdf_front, jdf_queue, jdf_back.
// Throughput: one frame character per cycle while out_ready is high. Each item
// is a frame of 7 to 10 characters, so the rate of items is set by the
// single-character output port; items queue behind a frame in flight.
// Reset (synchronous, rst_n low) empties all stages and loads register defaults.
`default_nettype none

module joystick_to_drive_frame #(
  parameter int SAMPLE_BITS = 12
) (
  input  wire                clk,
  input  wire                rst_n,
  // sample items
  input  wire                in_valid,
  output logic               in_ready,
  input  jdf_pkg::jdf_in_t   in_data,
  // frame characters
  output logic               out_valid,
  input  wire                out_ready,
  output jdf_pkg::jdf_out_t  out_data,
  // configuration
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire  [3:0]         paddr,
  input  wire  [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import jdf_pkg::*;

  logic [11:0] centre_r;
  logic [10:0] dead_r;
  logic [11:0] high_r;
  logic [11:0] low_r;
  logic        cfg_wr;
  jdf_cfg_t    cfg;
  logic        q_full, q_push, q_pop, q_valid;
  jdf_job_t    q_in, q_head;

  // Register file
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      centre_r <= CENTRE_RST;
      dead_r   <= DEAD_RST;
      high_r   <= HIGH_RST;
      low_r    <= LOW_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_CENTRE: centre_r <= pwdata[11:0];
        REG_DEAD:   dead_r   <= pwdata[10:0];
        REG_HIGH:   high_r   <= pwdata[11:0];
        REG_LOW:    low_r    <= pwdata[11:0];
        default:    ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (paddr[3:2])
      REG_CENTRE: prdata = {20'd0, centre_r};
      REG_DEAD:   prdata = {21'd0, dead_r};
      REG_HIGH:   prdata = {20'd0, high_r};
      REG_LOW:    prdata = {20'd0, low_r};
      default:    prdata = 32'd0;
    endcase
  end

  always_comb begin
    cfg.centre_value   = centre_r;
    cfg.dead_zone      = dead_r;
    cfg.high_threshold = high_r;
    cfg.low_threshold  = low_r;
  end

  jdf_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cfg      (cfg),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  jdf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_head)
  );

  jdf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: tb/joystick_to_drive_frame_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for joystick_to_drive_frame: a directed table, then random sample
// items under several register settings; bytes checked against typed-in or predicted frames.
// Depends on jdf_pkg and the joystick_to_drive_frame RTL.

module joystick_to_drive_frame_tb;
  import jdf_pkg::*;

  localparam int CLK_HALF      = 2;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int RAND_PHASES   = 5;
  localparam int PHASE_ITEMS   = 40;
  localparam int BURST_ITEMS   = 30;
  localparam int MAX_PRINTS    = 40;
  localparam int SPEED_CLAMP   = 1300;
  localparam int SPEED_SCALE   = 1000;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // One row of the directed table: an item (with optional typed-in frame) or a register set
  typedef struct {
    row_kind_t kind;
    jdf_in_t   item;
    jdf_cfg_t  cfg;
    string     frame;
  } plan_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  jdf_in_t     in_data;
  logic        out_valid;
  logic        out_ready;
  jdf_out_t    out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  jdf_cfg_t  live_cfg;
  jdf_out_t  pending_chars[$];
  plan_row_t plan[$];
  int        fault_count = 0;
  int        cycle_count = 0;
  bit        rx_hold_req = 1'b0;
  bit        rx_steady   = 1'b0;
  bit        tx_steady   = 1'b0;

  joystick_to_drive_frame dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  // Run guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic flag_fault(input string msg);
    fault_count++;
    if (fault_count <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------- predictor
  function automatic int unsigned speed_from(input logic [11:0] s);
    int unsigned span;
    span = (s > live_cfg.centre_value) ? s - live_cfg.centre_value
                                       : live_cfg.centre_value - s;
    if (span < live_cfg.dead_zone) return 0;
    span = span - live_cfg.dead_zone;
    if (span > SPEED_CLAMP) span = SPEED_CLAMP;
    return (span * span * SPEED_SCALE) / (SPEED_CLAMP * SPEED_CLAMP);
  endfunction

  task automatic queue_text(input string txt);
    jdf_out_t ch;
    for (int i = 0; i < txt.len(); i++) begin
      ch.frame_byte = txt[i];
      ch.last_byte  = (i == txt.len() - 1);
      pending_chars.push_back(ch);
    end
  endtask

  // Y decides first, then X; auto mode or a centred stick gives the stop frame
  task automatic predict_frame(input jdf_in_t it);
    logic [7:0]  dir;
    int unsigned spd;
    dir = CH_S;
    spd = 0;
    if (!it.auto_mode) begin
      if (it.y_sample > live_cfg.high_threshold) begin
        dir = CH_F; spd = speed_from(it.y_sample);
      end else if (it.y_sample < live_cfg.low_threshold) begin
        dir = CH_B; spd = speed_from(it.y_sample);
      end else if (it.x_sample > live_cfg.high_threshold) begin
        dir = CH_R; spd = speed_from(it.x_sample);
      end else if (it.x_sample < live_cfg.low_threshold) begin
        dir = CH_L; spd = speed_from(it.x_sample);
      end
    end
    queue_text($sformatf("$M,%c,%0d#", dir, spd));
  endtask

  // ---------------------------------------------------------------- register port
  task automatic write_reg(input logic [1:0] idx, input logic [11:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic read_check(input logic [1:0] idx, input logic [31:0] want);
    logic [31:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    got = prdata;
    if (got !== want)
      flag_fault($sformatf("register %0d reads 0x%08h, want 0x%08h", idx, got, want));
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_cfg(input jdf_cfg_t c);
    write_reg(REG_CENTRE, c.centre_value);
    write_reg(REG_DEAD,   12'(c.dead_zone));
    write_reg(REG_HIGH,   c.high_threshold);
    write_reg(REG_LOW,    c.low_threshold);
    live_cfg = c;
    read_check(REG_CENTRE, 32'(c.centre_value));
    read_check(REG_DEAD,   32'(c.dead_zone));
    read_check(REG_HIGH,   32'(c.high_threshold));
    read_check(REG_LOW,    32'(c.low_threshold));
  endtask

  // ---------------------------------------------------------------- sample side
  task automatic send_item(input jdf_in_t it, input string frame);
    int gap;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    if (frame.len() != 0) queue_text(frame);
    else predict_frame(it);
    // gap before the next item: mostly none or short, now and then long
    if (tx_steady) gap = 0;
    else if ($urandom_range(0, 19) == 0) gap = $urandom_range(15, 40);
    else if ($urandom_range(0, 1) == 0) gap = 0;
    else gap = $urandom_range(1, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering items and let every expected byte come out
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [11:0] pick_level(input logic [11:0] dflt);
    case ($urandom_range(0, 5))
      0:       return 12'd0;
      1:       return 12'hFFF;
      2:       return dflt;
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  // Samples biased towards the thresholds and the dead zone edges
  function automatic logic [11:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 12'd0;
      1: return 12'hFFF;
      2: return live_cfg.high_threshold + 12'($urandom_range(0, 2)) - 12'd1;
      3: return live_cfg.low_threshold + 12'($urandom_range(0, 2)) - 12'd1;
      4: return live_cfg.centre_value + 12'(live_cfg.dead_zone)
                + 12'($urandom_range(0, 1400));
      5: return live_cfg.centre_value - 12'(live_cfg.dead_zone)
                - 12'($urandom_range(0, 1400));
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic plan_row_t make_item(input logic [11:0] x, input logic [11:0] y,
                                          input logic a, input string frame);
    plan_row_t r;
    r.kind  = ROW_ITEM;
    r.item  = '{x_sample: x, y_sample: y, auto_mode: a};
    r.cfg   = '0;
    r.frame = frame;
    return r;
  endfunction

  function automatic plan_row_t make_cfg(input logic [11:0] c, input logic [10:0] d,
                                         input logic [11:0] h, input logic [11:0] l);
    plan_row_t r;
    r.kind  = ROW_CFG;
    r.item  = '0;
    r.cfg   = '{centre_value: c, dead_zone: d, high_threshold: h, low_threshold: l};
    r.frame = "";
    return r;
  endfunction

  // ---------------------------------------------------------------- result side
  initial begin : rx_side
    int len;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        // long hold-off so the block fills and stalls its input
        rx_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 4);
        out_ready <= rx_steady || ($urandom_range(0, 3) != 0);
        repeat (len) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : frame_check
    jdf_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_chars.size() == 0) begin
        flag_fault($sformatf("byte 0x%02h with no frame pending", out_data.frame_byte));
      end else begin
        want = pending_chars.pop_front();
        if (out_data.frame_byte !== want.frame_byte)
          flag_fault($sformatf("frame_byte 0x%02h, want 0x%02h",
                               out_data.frame_byte, want.frame_byte));
        if (out_data.last_byte !== want.last_byte)
          flag_fault($sformatf("last_byte %0b, want %0b on 0x%02h",
                               out_data.last_byte, want.last_byte, want.frame_byte));
      end
    end
  end

  // ---------------------------------------------------------------- main sequence
  initial begin : stimulus
    jdf_cfg_t c;
    jdf_in_t  it;
    in_valid <= 1'b0;
    in_data  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    rst_n    <= 1'b0;
    live_cfg = '{centre_value: CENTRE_RST, dead_zone: DEAD_RST,
                 high_threshold: HIGH_RST, low_threshold: LOW_RST};

    // Directed table, reset settings first
    plan.push_back(make_item(12'd2048, 12'd2048, 1'b0, "$M,S,0#"));
    plan.push_back(make_item(12'hFFF,  12'hFFF,  1'b1, "$M,S,0#"));
    plan.push_back(make_item(12'd0,    12'd0,    1'b1, "$M,S,0#"));
    plan.push_back(make_item(12'd2048, 12'hFFF,  1'b0, "$M,F,1000#"));
    plan.push_back(make_item(12'd2048, 12'd0,    1'b0, "$M,B,1000#"));
    plan.push_back(make_item(12'hFFF,  12'd2048, 1'b0, "$M,R,1000#"));
    plan.push_back(make_item(12'd0,    12'd2048, 1'b0, "$M,L,1000#"));
    plan.push_back(make_item(12'd0,    12'hFFF,  1'b0, "$M,F,1000#"));
    plan.push_back(make_item(12'hFFF,  12'd2350, 1'b0, "$M,R,1000#"));
    plan.push_back(make_item(12'd2048, 12'd1750, 1'b0, "$M,S,0#"));
    plan.push_back(make_item(12'd2048, 12'd2351, 1'b0, ""));  // just past threshold
    plan.push_back(make_item(12'd2048, 12'd2478, 1'b0, ""));  // two digits
    plan.push_back(make_item(12'd2048, 12'd2760, 1'b0, ""));  // three digits
    plan.push_back(make_item(12'd1749, 12'd2048, 1'b0, ""));
    plan.push_back(make_item(12'd2351, 12'd1750, 1'b0, ""));
    plan.push_back(make_item(12'hAAA,  12'h555,  1'b0, ""));
    plan.push_back(make_item(12'h555,  12'hAAA,  1'b0, ""));
    // crossed thresholds: order of checks still decides
    plan.push_back(make_cfg(12'd2048, 11'd0, 12'd1000, 12'd3000));
    plan.push_back(make_item(12'd2048, 12'd2000, 1'b0, "$M,F,1#"));
    plan.push_back(make_item(12'hFFF,  12'd500,  1'b0, "$M,B,1000#"));
    plan.push_back(make_item(12'd0,    12'd1000, 1'b0, ""));
    // widest dead zone, thresholds out of reach
    plan.push_back(make_cfg(12'd0, 11'h7FF, 12'hFFF, 12'd0));
    plan.push_back(make_item(12'hFFF,  12'hFFF,  1'b0, "$M,S,0#"));
    plan.push_back(make_item(12'd0,    12'd0,    1'b0, "$M,S,0#"));
    // centre at the top, no dead zone: distance saturates
    plan.push_back(make_cfg(12'hFFF, 11'd0, 12'd0, 12'hFFF));
    plan.push_back(make_item(12'd0,    12'd1,    1'b0, "$M,F,1000#"));
    plan.push_back(make_item(12'hFFF,  12'd0,    1'b0, "$M,B,1000#"));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Register defaults after reset
    read_check(REG_CENTRE, 32'(CENTRE_RST));
    read_check(REG_DEAD,   32'(DEAD_RST));
    read_check(REG_HIGH,   32'(HIGH_RST));
    read_check(REG_LOW,    32'(LOW_RST));

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        drain();
        apply_cfg(plan[i].cfg);
      end else begin
        send_item(plan[i].item, plan[i].frame);
      end
    end

    // Random phases, each under its own register setting
    for (int p = 0; p < RAND_PHASES; p++) begin
      drain();
      if (p == 0) begin
        c = '{centre_value: CENTRE_RST, dead_zone: DEAD_RST,
              high_threshold: HIGH_RST, low_threshold: LOW_RST};
      end else begin
        c.centre_value   = pick_level(CENTRE_RST);
        c.dead_zone      = 11'(pick_level(12'(DEAD_RST)));
        c.high_threshold = pick_level(HIGH_RST);
        c.low_threshold  = pick_level(LOW_RST);
      end
      apply_cfg(c);
      rx_steady = (p == 3);
      tx_steady = (p == 3);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 2 && k == 0) begin
          // receiver holds off while items keep coming back to back
          rx_hold_req = 1'b1;
          tx_steady   = 1'b1;
        end
        if (p == 2 && k == BURST_ITEMS) begin
          tx_steady = 1'b0;
          drain();
        end
        if (p == 3 && k == PHASE_ITEMS / 2) begin
          rx_steady = 1'b0;
          tx_steady = 1'b0;
        end
        it.x_sample  = pick_sample();
        it.y_sample  = pick_sample();
        it.auto_mode = ($urandom_range(0, 7) == 0);
        send_item(it, "");
      end
    end

    drain();
    if (fault_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
